### rtl/core/kbm_pkg.sv
// Shared types and constants for the keyboard report merger.
package kbm_pkg;

   localparam int unsigned DEVICE_COUNT_DEF = 4;
   localparam int unsigned KEY_SLOTS        = 6;
   localparam int unsigned KEY_IDX_W        = 3;

   localparam logic [1:0] FUNC_LOCAL  = 2'd0;
   localparam logic [1:0] FUNC_REMOTE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   typedef struct packed {
      logic [7:0]                mod;
      logic [KEY_SLOTS-1:0][7:0] keys;
   } report_type;

   // controller -> datapath commands
   typedef struct packed {
      logic store;     // request accepted: update storage, zero accumulator
      logic step;      // merge one key of the selected source
      logic load_out;  // copy accumulator into the response register
   } dp_cmd_type;

endpackage

### rtl/core/kbm_ctrl.sv
// Controller: request/response handshake and merge sequencing.
module kbm_ctrl import kbm_pkg::*; #(
   parameter int unsigned DEVICE_COUNT = DEVICE_COUNT_DEF,
   localparam int unsigned SRC_W = $clog2(DEVICE_COUNT + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dp_cmd_type           cmd,
   output logic [SRC_W-1:0]     src_sel,
   output logic [KEY_IDX_W-1:0] key_sel
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MERGE = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   localparam logic [SRC_W-1:0]     LAST_SRC = SRC_W'(DEVICE_COUNT);
   localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(KEY_SLOTS - 1);

   logic [1:0]           state_ff, state_in;
   logic [SRC_W-1:0]     src_ff, src_in;
   logic [KEY_IDX_W-1:0] key_ff, key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign src_sel   = src_ff;
   assign key_sel   = key_ff;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               src_in    = '0;
               key_in    = '0;
               state_in  = ST_MERGE;
            end
         end
         ST_MERGE: begin
            cmd.step = 1'b1;
            if (key_ff == LAST_KEY) begin
               key_in = '0;
               src_in = src_ff + 1'b1;
               if (src_ff == LAST_SRC) begin
                  state_in = ST_FLUSH;
               end
            end else begin
               key_in = key_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= '0;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/kbm_datapath.sv
// Datapath: stored reports, merge accumulator and response register.
module kbm_datapath import kbm_pkg::*; #(
   parameter int unsigned DEVICE_COUNT = DEVICE_COUNT_DEF,
   localparam int unsigned SRC_W  = $clog2(DEVICE_COUNT + 1),
   localparam int unsigned LIDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic [SRC_W-1:0]     src_sel,
   input  logic [KEY_IDX_W-1:0] key_sel,
   input  logic [1:0]           req_func,
   input  logic [3:0]           req_source_index,
   input  report_type           req_report,
   output report_type           rsp_report
);

   report_type local_ff [DEVICE_COUNT];
   report_type local_in [DEVICE_COUNT];
   report_type remote_ff, remote_in;
   report_type acc_ff, acc_in;
   report_type out_ff, out_in;

   report_type           src_rpt;
   logic [7:0]           code;
   logic                 hit;
   logic                 found;
   logic [KEY_IDX_W-1:0] first_idx;
   logic                 idx_ok;

   assign rsp_report = out_ff;
   assign idx_ok     = ({1'b0, req_source_index} < 5'(DEVICE_COUNT));

   // storage update on an accepted request
   always_comb begin
      local_in  = local_ff;
      remote_in = remote_ff;
      if (cmd.store) begin
         case (req_func)
            FUNC_LOCAL: begin
               if (idx_ok) begin
                  local_in[req_source_index[LIDX_W-1:0]] = req_report;
               end
            end
            FUNC_REMOTE: remote_in = req_report;
            FUNC_CLEAR: begin
               for (int i = 0; i < DEVICE_COUNT; i++) begin
                  local_in[i] = '0;
               end
               remote_in = '0;
            end
            default: ;
         endcase
      end
   end

   // source select: locals first, remote last
   always_comb begin
      src_rpt = remote_ff;
      if (src_sel < SRC_W'(DEVICE_COUNT)) begin
         src_rpt = local_ff[src_sel[LIDX_W-1:0]];
      end
      code = src_rpt.keys[key_sel];
   end

   // duplicate check and first free slot
   always_comb begin
      hit       = 1'b0;
      found     = 1'b0;
      first_idx = '0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (acc_ff.keys[j] == code) begin
            hit = 1'b1;
         end
         if (!found && acc_ff.keys[j] == 8'd0) begin
            found     = 1'b1;
            first_idx = KEY_IDX_W'(j);
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.store) begin
         acc_in = '0;
      end else if (cmd.step) begin
         if (key_sel == '0) begin
            acc_in.mod = acc_ff.mod | src_rpt.mod;
         end
         if (code != 8'd0 && !hit && found) begin
            acc_in.keys[first_idx] = code;
         end
      end
   end

   always_comb begin
      out_in = out_ff;
      if (cmd.load_out) begin
         out_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEVICE_COUNT; i++) begin
            local_ff[i] <= '0;
         end
         remote_ff <= '0;
      end else begin
         local_ff  <= local_in;
         remote_ff <= remote_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

endmodule

### rtl/core/keyboard_report_merger_unit.sv
// Keyboard report merger: top level joining controller and datapath.
// Sequence: an accepted request updates storage, then the merge walks every
//   stored report; the response becomes valid once the output register is free.
// Requests are taken only in idle, not during a merge; the merge visits one
//   key code per cycle over every stored report, set by the single compare unit.
// Reset (synchronous, active high): all stored reports zero, controller idle,
//   no response pending.
module keyboard_report_merger_unit import kbm_pkg::*; #(
   parameter int unsigned DEVICE_COUNT = DEVICE_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [3:0] req_source_index,
   input  logic [7:0] req_modifier_bits,
   input  logic [7:0] req_key_a,
   input  logic [7:0] req_key_b,
   input  logic [7:0] req_key_c,
   input  logic [7:0] req_key_d,
   input  logic [7:0] req_key_e,
   input  logic [7:0] req_key_f,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_merged_modifier,
   output logic [7:0] rsp_merged_a,
   output logic [7:0] rsp_merged_b,
   output logic [7:0] rsp_merged_c,
   output logic [7:0] rsp_merged_d,
   output logic [7:0] rsp_merged_e,
   output logic [7:0] rsp_merged_f
);

   localparam int unsigned SRC_W = $clog2(DEVICE_COUNT + 1);

   dp_cmd_type           cmd;
   logic [SRC_W-1:0]     src_sel;
   logic [KEY_IDX_W-1:0] key_sel;
   report_type           req_report;
   report_type           rsp_report;

   // pack the request into report form; keys[0] is slot a
   always_comb begin
      req_report.mod     = req_modifier_bits;
      req_report.keys[0] = req_key_a;
      req_report.keys[1] = req_key_b;
      req_report.keys[2] = req_key_c;
      req_report.keys[3] = req_key_d;
      req_report.keys[4] = req_key_e;
      req_report.keys[5] = req_key_f;
   end

   assign rsp_merged_modifier = rsp_report.mod;
   assign rsp_merged_a        = rsp_report.keys[0];
   assign rsp_merged_b        = rsp_report.keys[1];
   assign rsp_merged_c        = rsp_report.keys[2];
   assign rsp_merged_d        = rsp_report.keys[3];
   assign rsp_merged_e        = rsp_report.keys[4];
   assign rsp_merged_f        = rsp_report.keys[5];

   // Sequencer: idle -> merge over every (source, key) pair -> flush to output.
   // The output register lets a new request enter while a response waits.
   kbm_ctrl #(
      .DEVICE_COUNT (DEVICE_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .src_sel   (src_sel),
      .key_sel   (key_sel)
   );

   // Storage is written on the accept edge, so the merge sees the new state.
   kbm_datapath #(
      .DEVICE_COUNT (DEVICE_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .src_sel          (src_sel),
      .key_sel          (key_sel),
      .req_func         (req_func),
      .req_source_index (req_source_index),
      .req_report       (req_report),
      .rsp_report       (rsp_report)
   );

endmodule

### rtl/core/kbm_checker.sv
// Port-level assertions for the keyboard report merger, bound to the top level.
module kbm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_merged_modifier,
   input logic [7:0] rsp_merged_a,
   input logic [7:0] rsp_merged_f
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_merged_modifier)
         && $stable(rsp_merged_a) && $stable(rsp_merged_f))
      else $error("response changed while stalled");

   // one request at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while merge in progress");

   // a response only appears at the end of a merge
   a_rsp_from_merge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a merge");

   // clean state on the first cycle out of reset
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind keyboard_report_merger_unit kbm_checker u_kbm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_merged_modifier (rsp_merged_modifier),
   .rsp_merged_a        (rsp_merged_a),
   .rsp_merged_f        (rsp_merged_f)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for keyboard_report_merger_unit: directed and random requests checked against a local model.
module tb_top;
   import kbm_pkg::*;

   // DUT configuration and timing
   localparam int unsigned DEVICES       = DEVICE_COUNT_DEF;
   localparam logic [1:0]  FUNC_UNUSED   = 2'd3;         // spare func code, must be a no-op
   localparam int          DRAIN_CYCLES  = 6 * (DEVICES + 1) + 10;
   localparam int          PHASE_REQUESTS = 330;         // three phases, about 1000 requests

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_LOCAL;
   logic [3:0] req_source_index = '0;
   logic [7:0] req_modifier_bits = '0;
   logic [7:0] req_key_a = '0;
   logic [7:0] req_key_b = '0;
   logic [7:0] req_key_c = '0;
   logic [7:0] req_key_d = '0;
   logic [7:0] req_key_e = '0;
   logic [7:0] req_key_f = '0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_merged_modifier;
   logic [7:0] rsp_merged_a;
   logic [7:0] rsp_merged_b;
   logic [7:0] rsp_merged_c;
   logic [7:0] rsp_merged_d;
   logic [7:0] rsp_merged_e;
   logic [7:0] rsp_merged_f;

   // Model state: last report per local keyboard plus the remote one.
   // Key slot 0 of a report_type here maps to key_a / merged_a.
   report_type held_local [DEVICES];
   report_type held_remote;
   report_type merged_queue [$];   // merged reports still owed by the DUT

   int error_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   keyboard_report_merger_unit #(
      .DEVICE_COUNT(DEVICES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_source_index   (req_source_index),
      .req_modifier_bits  (req_modifier_bits),
      .req_key_a          (req_key_a),
      .req_key_b          (req_key_b),
      .req_key_c          (req_key_c),
      .req_key_d          (req_key_d),
      .req_key_e          (req_key_e),
      .req_key_f          (req_key_f),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_merged_modifier(rsp_merged_modifier),
      .rsp_merged_a       (rsp_merged_a),
      .rsp_merged_b       (rsp_merged_b),
      .rsp_merged_c       (rsp_merged_c),
      .rsp_merged_d       (rsp_merged_d),
      .rsp_merged_e       (rsp_merged_e),
      .rsp_merged_f       (rsp_merged_f)
   );

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic report_type make_report(input logic [7:0] m, input logic [7:0] a,
                                              input logic [7:0] b, input logic [7:0] c,
                                              input logic [7:0] d, input logic [7:0] e,
                                              input logic [7:0] f);
      report_type r;
      r.mod     = m;
      r.keys[0] = a;
      r.keys[1] = b;
      r.keys[2] = c;
      r.keys[3] = d;
      r.keys[4] = e;
      r.keys[5] = f;
      return r;
   endfunction

   // Merge of all held reports: modifiers ORed; keys walked locals first
   // (ascending), then remote; each new nonzero code takes the first empty
   // slot, repeats and codes that find no room are dropped.
   function automatic report_type merged_view();
      report_type acc;
      report_type src;
      logic [7:0] code;
      bit         seen;
      bit         placed;
      acc = '0;
      for (int s = 0; s <= DEVICES; s++) begin
         src = (s < DEVICES) ? held_local[s] : held_remote;
         acc.mod = acc.mod | src.mod;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            code = src.keys[i];
            seen = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
               if (acc.keys[j] == code) seen = 1'b1;
            if (code != 8'd0 && !seen) begin
               placed = 1'b0;
               for (int j = 0; j < KEY_SLOTS; j++) begin
                  if (!placed && acc.keys[j] == 8'd0) begin
                     acc.keys[j] = code;
                     placed = 1'b1;
                  end
               end
            end
         end
      end
      return acc;
   endfunction

   // Drive one request at the falling edge, hold it until accepted, then
   // update the model. Valid stays high into the next call so back-to-back
   // requests are possible; the idle loop drops it for a gap.
   task automatic send_request(input logic [1:0] func, input logic [3:0] idx,
                               input report_type rpt);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_func          = func;
      req_source_index  = idx;
      req_modifier_bits = rpt.mod;
      req_key_a         = rpt.keys[0];
      req_key_b         = rpt.keys[1];
      req_key_c         = rpt.keys[2];
      req_key_d         = rpt.keys[3];
      req_key_e         = rpt.keys[4];
      req_key_f         = rpt.keys[5];
      req_valid         = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (func)
         FUNC_LOCAL:  if (idx < DEVICES) held_local[idx] = rpt;
         FUNC_REMOTE: held_remote = rpt;
         FUNC_CLEAR: begin
            foreach (held_local[k]) held_local[k] = '0;
            held_remote = '0;
         end
         default: ;
      endcase
      merged_queue.push_back(merged_view());
      @(negedge clock);
   endtask

   // Response side: random backpressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   // Compare every accepted response with the oldest expected merge
   always @(posedge clock) begin : check_rsp
      report_type got;
      report_type want;
      string      slot_name [KEY_SLOTS];
      slot_name = '{"a", "b", "c", "d", "e", "f"};
      if (!reset && rsp_valid && rsp_ready) begin
         got = make_report(rsp_merged_modifier, rsp_merged_a, rsp_merged_b, rsp_merged_c,
                           rsp_merged_d, rsp_merged_e, rsp_merged_f);
         if (merged_queue.size() == 0) begin
            report_mismatch($sformatf("response with none pending: %h", got));
         end else begin
            want = merged_queue.pop_front();
            if (got.mod !== want.mod)
               report_mismatch($sformatf("merged_modifier got %h want %h",
                                         got.mod, want.mod));
            for (int i = 0; i < KEY_SLOTS; i++)
               if (got.keys[i] !== want.keys[i])
                  report_mismatch($sformatf("merged_%s got %h want %h",
                                            slot_name[i], got.keys[i], want.keys[i]));
         end
      end
   end

   // Locals at both ends of the index range, overwrite, all-ones/all-zeros data
   task automatic test_local_store();
      send_request(FUNC_LOCAL, 4'd0, make_report(8'hFF, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h02));
      send_request(FUNC_LOCAL, 4'(DEVICES - 1),
                   make_report(8'h00, 8'h04, 8'h00, 8'h05, 8'h00, 8'h00, 8'h06));
      send_request(FUNC_LOCAL, 4'd0, make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(FUNC_LOCAL, 4'd1, make_report(8'h81, 8'h06, 8'h07, 8'h04, 8'h00, 8'h08, 8'h00));
   endtask

   // Remote store ignores the index; codes shared with locals are not repeated
   task automatic test_remote_store();
      send_request(FUNC_REMOTE, 4'hF, make_report(8'h42, 8'h07, 8'h09, 8'h00, 8'h04, 8'h0A, 8'h00));
      send_request(FUNC_REMOTE, 4'd2, make_report(8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0B));
   endtask

   // Out-of-range local index and the spare func code change nothing
   task automatic test_ignored_requests();
      send_request(FUNC_LOCAL, 4'(DEVICES), make_report(8'hFF, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16));
      send_request(FUNC_LOCAL, 4'hF, make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(FUNC_UNUSED, 4'd0, make_report(8'hFF, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26));
      send_request(FUNC_UNUSED, 4'hA, make_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // More distinct codes than slots; duplicates inside one report; zero gaps
   task automatic test_key_overflow();
      send_request(FUNC_LOCAL, 4'd0, make_report(8'h01, 8'h00, 8'h31, 8'h31, 8'h00, 8'h32, 8'h31));
      send_request(FUNC_LOCAL, 4'd1, make_report(8'h02, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38));
      send_request(FUNC_LOCAL, 4'd2, make_report(8'h04, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46));
      send_request(FUNC_LOCAL, 4'(DEVICES - 1),
                   make_report(8'h08, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56));
      send_request(FUNC_REMOTE, 4'd0, make_report(8'h10, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66));
      send_request(FUNC_LOCAL, 4'd0, make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // Clear wipes everything regardless of payload; storing afterwards works
   task automatic test_clear_all();
      send_request(FUNC_CLEAR, 4'hF, make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(FUNC_REMOTE, 4'd0, make_report(8'h20, 8'h2C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(FUNC_CLEAR, 4'd0, make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   // Random traffic: mostly in-range stores with keys from a small pool so
   // duplicates and overflow are frequent; some clears and ignored requests.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      logic [1:0] func;
      logic [3:0] idx;
      report_type rpt;
      int         pick;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
         rpt.mod = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
         for (int i = 0; i < KEY_SLOTS; i++) begin
            pick = $urandom_range(9);
            if (pick < 3)      rpt.keys[i] = 8'h00;
            else if (pick < 7) rpt.keys[i] = 8'($urandom_range(12, 1));
            else               rpt.keys[i] = 8'($urandom_range(255));
         end
         idx  = ($urandom_range(99) < 85) ? 4'($urandom_range(DEVICES - 1))
                                          : 4'($urandom_range(15));
         pick = $urandom_range(99);
         if (pick < 58)      func = FUNC_LOCAL;
         else if (pick < 84) func = FUNC_REMOTE;
         else if (pick < 92) func = FUNC_CLEAR;
         else                func = FUNC_UNUSED;
         send_request(func, idx, rpt);
      end
   endtask

   initial begin
      foreach (held_local[k]) held_local[k] = '0;
      held_remote = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idle_pct    = 31;
      receiver_stall_pct = 47;
      test_local_store();
      test_remote_store();
      test_ignored_requests();
      test_key_overflow();
      test_clear_all();

      test_random_traffic(31, 47);
      test_random_traffic(47, 31);
      test_random_traffic(0, 0);
      req_valid = 1'b0;

      // drain outstanding merges, then watch for stray responses
      while (merged_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
